// ===== rtl/pcw_pkg.sv =====
package pcw_pkg;

    // field widths
    localparam int CW       = 48;
    localparam int IDX_W    = 5;
    localparam int DIGIT_W  = 24;
    localparam int ACC_W    = 200;

    // coefficient table layout
    localparam int TABLE_DEPTH = 20;
    localparam int N_COEF      = 18;
    localparam int N_TERMS     = 9;
    localparam int OFF_X_IDX   = 18;
    localparam int OFF_Y_IDX   = 19;

    // pipeline timing
    localparam int MUL_LAT  = 3;
    localparam int TREE_LAT = 4;

    // alignment to 80 fraction bits
    localparam int SH_DEG1 = 32;
    localparam int SH_DEG2 = 16;
    localparam int SH_OFF  = 48;

    // rounding and result window
    localparam int RND_POS = 63;
    localparam int RES_LSB = 64;

    localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

    // item function codes
    localparam logic FUNC_XFORM = 1'b0;
    localparam logic FUNC_LOAD  = 1'b1;

    typedef struct packed {
        logic [CW-1:0]                xmag;
        logic [CW-1:0]                ymag;
        logic                         sx;
        logic                         sy;
        logic                         order0;
        logic [CW-1:0]                xraw;
        logic [CW-1:0]                yraw;
        logic [N_COEF-1:0]            csgn;
        logic [N_COEF-1:0][CW-1:0]    cmag;
        logic [1:0][CW-1:0]           offs;
    } side_t;

    typedef struct packed {
        side_t                        side;
        logic [2:0][2*CW-1:0]         quad;
    } mid_t;

    typedef struct packed {
        logic                         order0;
        logic [CW-1:0]                xraw;
        logic [CW-1:0]                yraw;
        logic [N_COEF-1:0]            tsgn;
        logic [1:0][CW-1:0]           offs;
    } late_t;

    typedef struct packed {
        logic                         order0;
        logic [CW-1:0]                xraw;
        logic [CW-1:0]                yraw;
    } tail_t;

    function automatic logic [3:0] terms_for_order(input logic [1:0] order);
        logic [3:0] n;
        unique case (order)
            2'd0: n = 4'd0;
            2'd1: n = 4'd2;
            2'd2: n = 4'd5;
            2'd3: n = 4'd9;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/pcw_delay.sv =====
module pcw_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] sr_reg [N];

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg[0] <= d;
            for (int k = 1; k < N; k++) begin
                sr_reg[k] <= sr_reg[k-1];
            end
        end
    end

    assign q = sr_reg[N-1];

endmodule

// ===== rtl/pcw_mul.sv =====
// unsigned NA-digit by two-digit multiply, three register stages
module pcw_mul #(
    parameter int NA = 2
) (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic [NA*pcw_pkg::DIGIT_W-1:0]        a,
    input  logic [2*pcw_pkg::DIGIT_W-1:0]         b,
    output logic [(NA+2)*pcw_pkg::DIGIT_W-1:0]    p
);

    localparam int DW = pcw_pkg::DIGIT_W;
    localparam int RW = (NA + 1) * DW;
    localparam int PW = (NA + 2) * DW;

    logic [2*DW-1:0] pp_reg [2][NA];
    logic [RW-1:0]   row_reg [2];
    logic [RW-1:0]   row_next [2];
    logic [PW-1:0]   p_reg;

    // partial products
    for (genvar gj = 0; gj < 2; gj++) begin : g_row
        for (genvar gi = 0; gi < NA; gi++) begin : g_dig
            always_ff @(posedge aclk) begin
                if (en) begin
                    pp_reg[gj][gi] <= (2*DW)'(a[gi*DW +: DW]) * (2*DW)'(b[gj*DW +: DW]);
                end
            end
        end

        // even and odd partials do not overlap, so each set is a plain concatenation
        always_comb begin
            logic [RW-1:0] ev;
            logic [RW-1:0] od;
            ev = '0;
            od = '0;
            for (int i = 0; i < NA; i++) begin
                if (i[0]) begin
                    od[i*DW +: 2*DW] = pp_reg[gj][i];
                end else begin
                    ev[i*DW +: 2*DW] = pp_reg[gj][i];
                end
            end
            row_next[gj] = ev + od;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                row_reg[gj] <= row_next[gj];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= PW'(row_reg[0]) + {row_reg[1], {DW{1'b0}}};
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/pcw_tree.sv =====
// registered adder tree over ten two's complement terms
module pcw_tree (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic [9:0][pcw_pkg::ACC_W-1:0]        terms,
    output logic [pcw_pkg::ACC_W-1:0]             sum
);

    logic [pcw_pkg::ACC_W-1:0] l1_reg [5];
    logic [pcw_pkg::ACC_W-1:0] l2_reg [3];
    logic [pcw_pkg::ACC_W-1:0] l3_reg [2];
    logic [pcw_pkg::ACC_W-1:0] s_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 5; k++) begin
                l1_reg[k] <= terms[2*k] + terms[2*k+1];
            end
            l2_reg[0] <= l1_reg[0] + l1_reg[1];
            l2_reg[1] <= l1_reg[2] + l1_reg[3];
            l2_reg[2] <= l1_reg[4];
            l3_reg[0] <= l2_reg[0] + l2_reg[1];
            l3_reg[1] <= l2_reg[2];
            s_reg     <= l3_reg[0] + l3_reg[1];
        end
    end

    assign sum = s_reg;

endmodule

// ===== rtl/polynomial_coordinate_warp.sv =====
// each transform result passes the front, multiply, sign, tree and output registers
// throughput: one item per cycle while the pipeline advances; a load gives no result
// every stage advances together whenever the output register is empty or taken
// reset (aresetn low, synchronous): clears the pipeline valid bits, the order
// register and all 20 coefficient words; payload registers are not reset
module polynomial_coordinate_warp (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration: polynomial order
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_wr_data,
    // input item channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_func,
    input  logic [pcw_pkg::IDX_W-1:0]         s_coef_index,
    input  logic signed [pcw_pkg::CW-1:0]     s_coef_value,
    input  logic signed [pcw_pkg::CW-1:0]     s_x_in,
    input  logic signed [pcw_pkg::CW-1:0]     s_y_in,
    // result item channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pcw_pkg::CW-1:0]     m_x_out,
    output logic signed [pcw_pkg::CW-1:0]     m_y_out,
    output logic                              m_overflow
);

    localparam int CW    = pcw_pkg::CW;
    localparam int ACC_W = pcw_pkg::ACC_W;
    // front register, three multiply levels, sign stage, tree, output register
    localparam int LAT   = 1 + 3 * pcw_pkg::MUL_LAT + 1 + pcw_pkg::TREE_LAT + 1;

    // magnitude of a 48-bit two's complement word, -2^47 maps to 2^47
    function automatic logic [CW-1:0] mag48(input logic [CW-1:0] v);
        return v[CW-1] ? (~v + CW'(1)) : v;
    endfunction

    // round half up to 16 fraction bits and saturate to 48 bits
    function automatic logic [CW:0] round_sat(input logic [ACC_W-1:0] acc);
        logic [ACC_W-1:0] r;
        logic             fits;
        r    = acc + (ACC_W'(1) << pcw_pkg::RND_POS);
        fits = (r[ACC_W-1:pcw_pkg::RES_LSB+CW-1] == '0) ||
               (r[ACC_W-1:pcw_pkg::RES_LSB+CW-1] == '1);
        if (fits) begin
            return {1'b0, r[pcw_pkg::RES_LSB +: CW]};
        end
        return {1'b1, r[ACC_W-1] ? pcw_pkg::SAT_MIN : pcw_pkg::SAT_MAX};
    endfunction

    // ------------------------------------------------------------------
    // handshake and global advance
    // ------------------------------------------------------------------
    logic [LAT-1:0] vld_reg;
    logic           adv;
    logic           accept;
    logic           xform;

    // the whole pipeline moves when the output slot is free or being taken
    assign adv     = !vld_reg[LAT-1] || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && s_ready;
    assign xform   = accept && (s_func == pcw_pkg::FUNC_XFORM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], xform};
        end
    end

    // ------------------------------------------------------------------
    // order register and coefficient table
    // ------------------------------------------------------------------
    logic [1:0]    poly_order_reg;
    logic [CW-1:0] coef_tbl_reg [pcw_pkg::TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_order_reg <= 2'd0;
        end else if (cfg_wr_en) begin
            poly_order_reg <= cfg_wr_data;
        end
    end

    // load items write one word at accept time; slots past the table are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < pcw_pkg::TABLE_DEPTH; k++) begin
                coef_tbl_reg[k] <= '0;
            end
        end else if (accept && (s_func == pcw_pkg::FUNC_LOAD) &&
                     (s_coef_index < pcw_pkg::IDX_W'(pcw_pkg::TABLE_DEPTH))) begin
            coef_tbl_reg[s_coef_index] <= s_coef_value;
        end
    end

    // ------------------------------------------------------------------
    // front stage: magnitudes, signs and a snapshot of the table
    // ------------------------------------------------------------------
    pcw_pkg::side_t side_next;
    pcw_pkg::side_t side_reg;
    logic [3:0]     nterms;

    assign nterms = pcw_pkg::terms_for_order(poly_order_reg);

    always_comb begin
        side_next.xmag   = mag48(s_x_in);
        side_next.ymag   = mag48(s_y_in);
        side_next.sx     = s_x_in[CW-1];
        side_next.sy     = s_y_in[CW-1];
        side_next.order0 = (poly_order_reg == 2'd0);
        side_next.xraw   = s_x_in;
        side_next.yraw   = s_y_in;
        for (int k = 0; k < pcw_pkg::N_COEF; k++) begin
            // terms above the current order contribute zero
            if ((k >> 1) < int'(nterms)) begin
                side_next.csgn[k] = coef_tbl_reg[k][CW-1];
                side_next.cmag[k] = mag48(coef_tbl_reg[k]);
            end else begin
                side_next.csgn[k] = 1'b0;
                side_next.cmag[k] = '0;
            end
        end
        side_next.offs[0] = coef_tbl_reg[pcw_pkg::OFF_X_IDX];
        side_next.offs[1] = coef_tbl_reg[pcw_pkg::OFF_Y_IDX];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg <= side_next;
        end
    end

    // ------------------------------------------------------------------
    // level 1: x^2, xy, y^2
    // ------------------------------------------------------------------
    logic [2*CW-1:0] quad [3];
    pcw_pkg::side_t  side_d1;

    pcw_mul #(.NA(2)) u_mul_xx (
        .aclk(aclk), .en(adv), .a(side_reg.xmag), .b(side_reg.xmag), .p(quad[0])
    );
    pcw_mul #(.NA(2)) u_mul_xy (
        .aclk(aclk), .en(adv), .a(side_reg.xmag), .b(side_reg.ymag), .p(quad[1])
    );
    pcw_mul #(.NA(2)) u_mul_yy (
        .aclk(aclk), .en(adv), .a(side_reg.ymag), .b(side_reg.ymag), .p(quad[2])
    );

    pcw_delay #(.W($bits(pcw_pkg::side_t)), .N(pcw_pkg::MUL_LAT)) u_dly_side (
        .aclk(aclk), .en(adv), .d(side_reg), .q(side_d1)
    );

    // ------------------------------------------------------------------
    // level 2: x^3, x^2y, xy^2, y^3
    // ------------------------------------------------------------------
    logic [3*CW-1:0] cubic [4];
    pcw_pkg::mid_t   mid_in;
    pcw_pkg::mid_t   mid_d2;

    pcw_mul #(.NA(4)) u_mul_xxx (
        .aclk(aclk), .en(adv), .a(quad[0]), .b(side_d1.xmag), .p(cubic[0])
    );
    pcw_mul #(.NA(4)) u_mul_xxy (
        .aclk(aclk), .en(adv), .a(quad[0]), .b(side_d1.ymag), .p(cubic[1])
    );
    pcw_mul #(.NA(4)) u_mul_xyy (
        .aclk(aclk), .en(adv), .a(quad[2]), .b(side_d1.xmag), .p(cubic[2])
    );
    pcw_mul #(.NA(4)) u_mul_yyy (
        .aclk(aclk), .en(adv), .a(quad[2]), .b(side_d1.ymag), .p(cubic[3])
    );

    assign mid_in.side    = side_d1;
    assign mid_in.quad[0] = quad[0];
    assign mid_in.quad[1] = quad[1];
    assign mid_in.quad[2] = quad[2];

    pcw_delay #(.W($bits(pcw_pkg::mid_t)), .N(pcw_pkg::MUL_LAT)) u_dly_mid (
        .aclk(aclk), .en(adv), .d(mid_in), .q(mid_d2)
    );

    // ------------------------------------------------------------------
    // level 3: monomial times coefficient, one unit per term and axis
    // ------------------------------------------------------------------
    logic [2*CW-1:0] lin_mono [2];
    logic [2*CW-1:0] prod1 [2][2];
    logic [3*CW-1:0] prod2 [3][2];
    logic [4*CW-1:0] prod3 [4][2];

    assign lin_mono[0] = (2*CW)'(mid_d2.side.xmag);
    assign lin_mono[1] = (2*CW)'(mid_d2.side.ymag);

    for (genvar gi = 0; gi < 2; gi++) begin : g_lin
        for (genvar ga = 0; ga < 2; ga++) begin : g_ax
            pcw_mul #(.NA(2)) u_mul (
                .aclk(aclk), .en(adv), .a(lin_mono[gi][CW-1:0]),
                .b(mid_d2.side.cmag[2*gi+ga]), .p(prod1[gi][ga])
            );
        end
    end

    for (genvar gi = 0; gi < 3; gi++) begin : g_quad
        for (genvar ga = 0; ga < 2; ga++) begin : g_ax
            pcw_mul #(.NA(4)) u_mul (
                .aclk(aclk), .en(adv), .a(mid_d2.quad[gi]),
                .b(mid_d2.side.cmag[2*(gi+2)+ga]), .p(prod2[gi][ga])
            );
        end
    end

    for (genvar gi = 0; gi < 4; gi++) begin : g_cub
        for (genvar ga = 0; ga < 2; ga++) begin : g_ax
            pcw_mul #(.NA(6)) u_mul (
                .aclk(aclk), .en(adv), .a(cubic[gi]),
                .b(mid_d2.side.cmag[2*(gi+5)+ga]), .p(prod3[gi][ga])
            );
        end
    end

    // term signs: monomial sign xor coefficient sign
    logic [pcw_pkg::N_TERMS-1:0] msgn;
    pcw_pkg::late_t              late_in;
    pcw_pkg::late_t              late_d3;

    always_comb begin
        msgn[0] = mid_d2.side.sx;
        msgn[1] = mid_d2.side.sy;
        msgn[2] = 1'b0;
        msgn[3] = mid_d2.side.sx ^ mid_d2.side.sy;
        msgn[4] = 1'b0;
        msgn[5] = mid_d2.side.sx;
        msgn[6] = mid_d2.side.sy;
        msgn[7] = mid_d2.side.sx;
        msgn[8] = mid_d2.side.sy;
        late_in.order0 = mid_d2.side.order0;
        late_in.xraw   = mid_d2.side.xraw;
        late_in.yraw   = mid_d2.side.yraw;
        late_in.offs   = mid_d2.side.offs;
        for (int k = 0; k < pcw_pkg::N_COEF; k++) begin
            late_in.tsgn[k] = msgn[k >> 1] ^ mid_d2.side.csgn[k];
        end
    end

    pcw_delay #(.W($bits(pcw_pkg::late_t)), .N(pcw_pkg::MUL_LAT)) u_dly_late (
        .aclk(aclk), .en(adv), .d(late_in), .q(late_d3)
    );

    // ------------------------------------------------------------------
    // sign stage: align every term to 80 fraction bits, two's complement
    // ------------------------------------------------------------------
    logic [ACC_W-1:0] term_mag [pcw_pkg::N_COEF];
    logic [ACC_W-1:0] term_reg [pcw_pkg::N_COEF];
    logic [ACC_W-1:0] off_reg  [2];

    for (genvar gi = 0; gi < 2; gi++) begin : g_al1
        for (genvar ga = 0; ga < 2; ga++) begin : g_ax
            assign term_mag[2*gi+ga] = ACC_W'(prod1[gi][ga]) << pcw_pkg::SH_DEG1;
        end
    end
    for (genvar gi = 0; gi < 3; gi++) begin : g_al2
        for (genvar ga = 0; ga < 2; ga++) begin : g_ax
            assign term_mag[2*(gi+2)+ga] = ACC_W'(prod2[gi][ga]) << pcw_pkg::SH_DEG2;
        end
    end
    for (genvar gi = 0; gi < 4; gi++) begin : g_al3
        for (genvar ga = 0; ga < 2; ga++) begin : g_ax
            assign term_mag[2*(gi+5)+ga] = ACC_W'(prod3[gi][ga]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < pcw_pkg::N_COEF; k++) begin
                term_reg[k] <= late_d3.tsgn[k] ? (~term_mag[k] + ACC_W'(1)) : term_mag[k];
            end
            for (int a = 0; a < 2; a++) begin
                // offsets are Q16.32: sign extend and move up to 80 fraction bits
                off_reg[a] <= {{(ACC_W-CW){late_d3.offs[a][CW-1]}}, late_d3.offs[a]}
                              << pcw_pkg::SH_OFF;
            end
        end
    end

    // ------------------------------------------------------------------
    // per-axis adder trees
    // ------------------------------------------------------------------
    logic [9:0][ACC_W-1:0] tx;
    logic [9:0][ACC_W-1:0] ty;
    logic [ACC_W-1:0]      sum_x;
    logic [ACC_W-1:0]      sum_y;

    always_comb begin
        for (int i = 0; i < pcw_pkg::N_TERMS; i++) begin
            tx[i] = term_reg[2*i];
            ty[i] = term_reg[2*i+1];
        end
        tx[9] = off_reg[0];
        ty[9] = off_reg[1];
    end

    pcw_tree u_tree_x (.aclk(aclk), .en(adv), .terms(tx), .sum(sum_x));
    pcw_tree u_tree_y (.aclk(aclk), .en(adv), .terms(ty), .sum(sum_y));

    // passthrough data rides alongside the sign stage and the tree
    pcw_pkg::tail_t tail_in;
    pcw_pkg::tail_t tail_d4;

    assign tail_in.order0 = late_d3.order0;
    assign tail_in.xraw   = late_d3.xraw;
    assign tail_in.yraw   = late_d3.yraw;

    pcw_delay #(.W($bits(pcw_pkg::tail_t)), .N(1 + pcw_pkg::TREE_LAT)) u_dly_tail (
        .aclk(aclk), .en(adv), .d(tail_in), .q(tail_d4)
    );

    // ------------------------------------------------------------------
    // output register: round, saturate, or pass the point through
    // ------------------------------------------------------------------
    logic [CW:0]   fin_x;
    logic [CW:0]   fin_y;
    logic [CW-1:0] x_out_reg;
    logic [CW-1:0] y_out_reg;
    logic          ovf_reg;

    assign fin_x = round_sat(sum_x);
    assign fin_y = round_sat(sum_y);

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (tail_d4.order0) begin
                // order zero leaves the point untouched
                x_out_reg <= tail_d4.xraw;
                y_out_reg <= tail_d4.yraw;
                ovf_reg   <= 1'b0;
            end else begin
                x_out_reg <= fin_x[CW-1:0];
                y_out_reg <= fin_y[CW-1:0];
                ovf_reg   <= fin_x[CW] | fin_y[CW];
            end
        end
    end

    assign m_valid    = vld_reg[LAT-1];
    assign m_x_out    = x_out_reg;
    assign m_y_out    = y_out_reg;
    assign m_overflow = ovf_reg;

`ifndef SYNTHESIS
    // a stalled pipeline keeps every valid bit in place
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    // an accepted load lands in the table on the next cycle
    a_load_written: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_func == pcw_pkg::FUNC_LOAD) &&
         (s_coef_index < pcw_pkg::IDX_W'(pcw_pkg::TABLE_DEPTH)))
        |=> (coef_tbl_reg[$past(s_coef_index)] == $past(s_coef_value)))
        else $error("coefficient load not stored");

    // overflow only comes with a saturated coordinate
    a_ovf_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_overflow) |->
        ((m_x_out == pcw_pkg::SAT_MAX) || (m_x_out == pcw_pkg::SAT_MIN) ||
         (m_y_out == pcw_pkg::SAT_MAX) || (m_y_out == pcw_pkg::SAT_MIN)))
        else $error("overflow without saturation");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (vld_reg == '0))
        else $error("pipeline not empty after reset");
`endif

endmodule
